/* rtl/power_sleep_controller_regs_defines.svh */
`ifndef POWER_SLEEP_CONTROLLER_REGS_DEFINES_SVH
`define POWER_SLEEP_CONTROLLER_REGS_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define PSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define PSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/psc_pkg.sv */
package psc_pkg;

  localparam int unsigned NUM_MODULES = 64;
  localparam int unsigned NUM_DOMAINS = 4;

  localparam logic [31:0] POP_MASK_B0 = 32'h0000_ba3f;
  localparam logic [31:0] POP_MASK_B1 = 32'h8733_3ffe;
  localparam logic [31:0] ON_MASK_B0  = 32'h0000_1800;
  localparam logic [31:0] ON_MASK_B1  = 32'h8700_0000;

  // upper 20 address bits of each 4 KiB bank window
  localparam logic [19:0] BANK0_PAGE = 20'h01c10;
  localparam logic [19:0] BANK1_PAGE = 20'h01e27;

  localparam logic [11:0] OFF_GO   = 12'h120;
  localparam logic [11:0] OFF_BUSY = 12'h128;
  // offset bits [11:7] of the status and control arrays
  localparam logic [4:0]  STATUS_REGION = 5'h10;
  localparam logic [4:0]  CTRL_REGION   = 5'h14;

  localparam logic [31:0] STATUS_BASE = 32'h0000_0b00;
  localparam logic [31:0] STATUS_HIGH = 32'h0000_0400;
  localparam logic [31:0] STATUS_ODD  = 32'h0000_1000;

  localparam logic [8:0]  CTRL_DSP   = 9'h103;
  localparam logic [4:0]  DSP_SLOT   = 5'd15;
  localparam logic [4:0]  LAST_SLOT  = 5'd31;
  localparam logic [1:0]  STATE_ON   = 2'd3;
  localparam logic [3:0]  WR_SIZE    = 4'd4;
  localparam logic [7:0]  TICKS_RESET = 8'd8;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } psc_op_t;

  typedef enum logic [3:0] {
    ACT_REJECT,
    ACT_RD_GO,
    ACT_RD_BUSY,
    ACT_RD_STATUS,
    ACT_RD_CTRL,
    ACT_WR_CTRL,
    ACT_WR_GO,
    ACT_WR_CHECK,
    ACT_TICK
  } psc_act_t;

  typedef struct packed {
    psc_act_t   act;
    logic       bank;
    logic [4:0] slot;
    logic [1:0] go_dom;
    logic [8:0] ctrl;
  } psc_dec_t;

  typedef struct packed {
    logic [8:0] ctrl;
    logic [1:0] st;
    logic [1:0] tgt;
  } psc_entry_t;

  function automatic logic psc_populated(input logic bank, input logic [4:0] slot);
    return bank ? POP_MASK_B1[slot] : POP_MASK_B0[slot];
  endfunction

  function automatic logic psc_always_on(input logic bank, input logic [4:0] slot);
    return bank ? ON_MASK_B1[slot] : ON_MASK_B0[slot];
  endfunction

  function automatic logic psc_domain(input logic bank, input logic [4:0] slot);
    return slot == (bank ? LAST_SLOT : DSP_SLOT);
  endfunction

  function automatic psc_entry_t psc_boot(input logic bank, input logic [4:0] slot);
    psc_entry_t e;
    logic       dsp;
    dsp = !bank && (slot == DSP_SLOT);
    e   = '0;
    if (psc_populated(bank, slot) && (psc_always_on(bank, slot) || dsp)) begin
      e.st   = STATE_ON;
      e.ctrl = 9'(STATE_ON);
    end
    if (dsp) begin
      e.ctrl[8] = 1'b1;
    end
    return e;
  endfunction

  function automatic logic [31:0] psc_status_word(input logic [1:0] st);
    return STATUS_BASE | 32'(st) | (st[1] ? STATUS_HIGH : '0) | (st[0] ? STATUS_ODD : '0);
  endfunction

endpackage

/* rtl/psc_decode.sv */
module psc_decode (
  input  logic [1:0]       in_opcode,
  input  logic [31:0]      in_bus_address,
  input  logic [63:0]      in_write_data,
  input  logic [3:0]       in_access_size,
  input  logic             in_commit,
  output psc_pkg::psc_dec_t dec
);
  import psc_pkg::*;

  logic        in_b0, in_b1, mapped, pop, ctrl_ok, go_ok;
  logic [11:0] off;
  logic [4:0]  slot;

  assign in_b0  = in_bus_address[31:12] == BANK0_PAGE;
  assign in_b1  = in_bus_address[31:12] == BANK1_PAGE;
  assign mapped = (in_bus_address[1:0] == 2'b00) && (in_b0 || in_b1);
  assign off    = in_bus_address[11:0];
  assign slot   = off[6:2];
  assign pop    = psc_populated(in_b1, slot);
  // the dsp slot takes only its one fixed value
  assign ctrl_ok = (!in_b1 && slot == DSP_SLOT) ? (in_write_data == 64'(CTRL_DSP))
                                                : (in_write_data[63:2] == '0);
  assign go_ok   = in_write_data[63:2] == '0;

  always_comb begin
    dec        = '0;
    dec.act    = ACT_REJECT;
    dec.bank   = in_b1;
    dec.slot   = slot;
    dec.go_dom = in_write_data[1:0];
    dec.ctrl   = in_write_data[8:0];
    case (psc_op_t'(in_opcode))
      OP_READ: begin
        if (mapped) begin
          if (off == OFF_GO) begin
            dec.act = ACT_RD_GO;
          end else if (off == OFF_BUSY) begin
            dec.act = ACT_RD_BUSY;
          end else if (off[11:7] == STATUS_REGION && pop) begin
            dec.act = ACT_RD_STATUS;
          end else if (off[11:7] == CTRL_REGION && pop) begin
            dec.act = ACT_RD_CTRL;
          end
        end
      end
      OP_WRITE: begin
        if (mapped && in_access_size == WR_SIZE) begin
          if (off[11:7] == CTRL_REGION) begin
            if (pop && ctrl_ok) begin
              dec.act = in_commit ? ACT_WR_CTRL : ACT_WR_CHECK;
            end
          end else if (off == OFF_GO && go_ok) begin
            dec.act = in_commit ? ACT_WR_GO : ACT_WR_CHECK;
          end
        end
      end
      OP_TICK: begin
        dec.act = ACT_TICK;
      end
      default: begin
        dec.act = ACT_REJECT;
      end
    endcase
  end

endmodule

/* rtl/power_sleep_controller_regs.sv */
// channel | direction | handshake           | payload
// in      | input     | in_valid/in_ready   | opcode, bus_address, write_data, size, commit
// out     | output    | out_valid/out_ready | accepted, read_data
// cfg     | input     | cfg_we              | cfg_wdata (transition_ticks)
//
// one item at a time; rejects, checks, GO and busy reads, GO or tick with no sweep go
// straight to S_RESP; status and control reads pass S_READ, control writes S_RMW; a GO
// that starts a domain or a tick that ends one passes S_SWEEP, a sweep of all 64 entries
// through the state memory, one read a cycle and a write of each eligible entry
// reset: synchronous, active low; a pass then loads the boot table, in_ready low, cfg
// writes taken; a held result lets the next item in and stalls it at its result
`include "power_sleep_controller_regs_defines.svh"

module power_sleep_controller_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_bus_address,
  input  logic [63:0] in_write_data,
  input  logic [3:0]  in_access_size,
  input  logic        in_commit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic [31:0] out_read_data,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);
  import psc_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_RMW,
    S_SWEEP,
    S_RESP
  } state_t;

  state_t     state_r;
  logic [5:0] init_idx_r;
  logic [6:0] sw_idx_r;   // top bit set once every entry has been read
  logic       sw_go_r;
  logic [NUM_DOMAINS-1:0] sw_mask_r;
  logic       p_vld_r;
  logic [5:0] p_idx_r;
  logic [7:0] cd_r [NUM_DOMAINS];
  logic [7:0] ticks_r;
  psc_act_t   act_r;
  logic [5:0] idx_r;
  logic [8:0] ctrl_r;
  logic       res_acc_r;
  logic [31:0] res_data_r;
  logic       out_valid_r, out_acc_r;
  logic [31:0] out_data_r;

  // per-module state: control, status state and target
  psc_entry_t mem_r [NUM_MODULES];
  psc_entry_t rd_data_r;

  psc_dec_t   dec;
  logic       accept;
  logic [5:0] idx_in;
  logic [7:0] cd_tick [NUM_DOMAINS];
  logic [NUM_DOMAINS-1:0] done_mask, go_mask;

  logic       mem_re, mem_we;
  logic [5:0] mem_raddr, mem_waddr;
  psc_entry_t mem_wdata, sweep_entry;
  logic       p_bank, p_elig;
  logic [4:0] p_slot;
  logic [1:0] p_k;

  psc_decode u_decode (
    .in_opcode      (in_opcode),
    .in_bus_address (in_bus_address),
    .in_write_data  (in_write_data),
    .in_access_size (in_access_size),
    .in_commit      (in_commit),
    .dec            (dec)
  );

  assign in_ready      = state_r == S_IDLE;
  assign accept        = in_valid && in_ready;
  assign idx_in        = {dec.bank, dec.slot};
  assign out_valid     = out_valid_r;
  assign out_accepted  = out_acc_r;
  assign out_read_data = out_data_r;

  // countdown step on a tick, and which domains a tick ends or a GO starts
  always_comb begin
    for (int k = 0; k < NUM_DOMAINS; k++) begin
      cd_tick[k]   = (cd_r[k] != '0) ? cd_r[k] - 8'd1 : cd_r[k];
      done_mask[k] = cd_r[k] == 8'd1;
      // a busy domain ignores GO
      go_mask[k]   = (dec.bank == k[1]) && dec.go_dom[k[0]] && (cd_r[k] == '0);
    end
  end

  // sweep: the entry read last cycle is updated and written back while the
  // next one is read, so the two never hit the same entry
  assign p_bank = p_idx_r[5];
  assign p_slot = p_idx_r[4:0];
  assign p_k    = {p_bank, psc_domain(p_bank, p_slot)};
  assign p_elig = p_vld_r && psc_populated(p_bank, p_slot) && sw_mask_r[p_k];

  always_comb begin
    sweep_entry = rd_data_r;
    if (sw_go_r) begin
      // GO latches the target: always-on slots go on, others follow control
      sweep_entry.tgt = psc_always_on(p_bank, p_slot) ? STATE_ON : rd_data_r.ctrl[1:0];
    end else begin
      // end of countdown: status takes the target
      sweep_entry.st = rd_data_r.tgt;
    end
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = idx_in;
    mem_we    = 1'b0;
    mem_waddr = p_idx_r;
    mem_wdata = sweep_entry;
    case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_idx_r;
        mem_wdata = psc_boot(init_idx_r[5], init_idx_r[4:0]);
      end
      S_IDLE: begin
        mem_re = accept && (dec.act == ACT_RD_STATUS || dec.act == ACT_RD_CTRL ||
                            dec.act == ACT_WR_CTRL);
      end
      S_RMW: begin
        // control write: keep status and target of the entry just read
        mem_we         = 1'b1;
        mem_waddr      = idx_r;
        mem_wdata      = rd_data_r;
        mem_wdata.ctrl = ctrl_r;
      end
      S_SWEEP: begin
        mem_re    = !sw_idx_r[6];
        mem_raddr = sw_idx_r[5:0];
        mem_we    = p_elig;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem_r[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_idx_r  <= '0;
      sw_idx_r    <= '0;
      p_vld_r     <= 1'b0;
      ticks_r     <= TICKS_RESET;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_DOMAINS; k++) begin
        cd_r[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        ticks_r <= cfg_wdata;
      end
      // in S_RESP the output register is handled below
      if (out_valid_r && out_ready && state_r != S_RESP) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_INIT: begin
          init_idx_r <= init_idx_r + 6'd1;
          if (init_idx_r == 6'(NUM_MODULES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            act_r      <= dec.act;
            idx_r      <= idx_in;
            ctrl_r     <= dec.ctrl;
            res_acc_r  <= dec.act != ACT_REJECT;
            res_data_r <= (dec.act == ACT_RD_BUSY) ?
                          {30'd0, cd_r[{dec.bank, 1'b1}] != '0,
                           cd_r[{dec.bank, 1'b0}] != '0} : '0;
            sw_idx_r   <= '0;
            case (dec.act)
              ACT_RD_BUSY: begin
                state_r <= S_RESP;
              end
              ACT_RD_STATUS, ACT_RD_CTRL: begin
                state_r <= S_READ;
              end
              ACT_WR_CTRL: begin
                state_r <= S_RMW;
              end
              ACT_WR_GO: begin
                for (int k = 0; k < NUM_DOMAINS; k++) begin
                  if (go_mask[k]) begin
                    cd_r[k] <= ticks_r;
                  end
                end
                sw_go_r   <= 1'b1;
                sw_mask_r <= go_mask;
                state_r   <= (go_mask != '0) ? S_SWEEP : S_RESP;
              end
              ACT_TICK: begin
                for (int k = 0; k < NUM_DOMAINS; k++) begin
                  cd_r[k] <= cd_tick[k];
                end
                sw_go_r   <= 1'b0;
                sw_mask_r <= done_mask;
                state_r   <= (done_mask != '0) ? S_SWEEP : S_RESP;
              end
              default: begin
                state_r <= S_RESP;
              end
            endcase
          end
        end
        S_READ: begin
          res_data_r <= (act_r == ACT_RD_STATUS) ? psc_status_word(rd_data_r.st)
                                                 : {23'd0, rd_data_r.ctrl};
          state_r    <= S_RESP;
        end
        S_RMW: begin
          state_r <= S_RESP;
        end
        S_SWEEP: begin
          p_vld_r <= !sw_idx_r[6];
          p_idx_r <= sw_idx_r[5:0];
          if (!sw_idx_r[6]) begin
            sw_idx_r <= sw_idx_r + 7'd1;
          end else begin
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          // result moves on once the output register is free or being emptied
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_acc_r   <= res_acc_r;
            out_data_r  <= res_data_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // one item in flight: a transfer closes the input until its result is out
  `PSC_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")
  // rejected accesses never carry read data
  `PSC_ASSERT_NOW(a_reject_zero, out_valid && !out_accepted, out_read_data == '0, "rejected access returned data")
  // a tick is always accepted and returns zero
  `PSC_ASSERT_NEXT(a_tick_ok, in_valid && in_ready && in_opcode == OP_TICK, res_acc_r && res_data_r == '0, "tick result wrong")

endmodule

/* test/psc_regs_checker.sv */
module psc_regs_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_bus_address,
  input  logic [63:0] in_write_data,
  input  logic [3:0]  in_access_size,
  input  logic        in_commit,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_accepted,
  input  logic [31:0] out_read_data,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output int unsigned error_count,
  output int unsigned responses_due
);
  import psc_pkg::*;

  localparam logic [63:0] CTRL_FIELD_MASK = 64'h3;

  typedef struct packed {
    logic        accepted;
    logic [31:0] read_data;
  } bus_resp_t;

  logic [8:0]  ctrl_q      [NUM_MODULES];
  logic [1:0]  state_q     [NUM_MODULES];
  logic [1:0]  target_q    [NUM_MODULES];
  logic [7:0]  countdown_q [NUM_DOMAINS];
  logic [7:0]  ticks_q;
  bus_resp_t   owed_results [$];
  int unsigned results_seen;

  initial begin
    error_count   = 0;
    responses_due = 0;
    results_seen  = 0;
  end

  function automatic logic slot_present(logic bank, logic [4:0] slot);
    return bank ? POP_MASK_B1[slot] : POP_MASK_B0[slot];
  endfunction

  function automatic logic slot_always_on(logic bank, logic [4:0] slot);
    return bank ? ON_MASK_B1[slot] : ON_MASK_B0[slot];
  endfunction

  // domain 1 is the dsp slot in bank 0 and the last slot in bank 1
  function automatic logic slot_domain(logic bank, logic [4:0] slot);
    return bank ? (slot == LAST_SLOT) : (slot == DSP_SLOT);
  endfunction

  function automatic logic [31:0] status_word(logic [1:0] st);
    logic [31:0] w;
    w = STATUS_BASE | 32'(st);
    if (st >= 2'd2) w |= STATUS_HIGH;
    if (st == 2'd1 || st == 2'd3) w |= STATUS_ODD;
    return w;
  endfunction

  function automatic void load_boot();
    logic       bank;
    logic [4:0] slot;
    logic       lit;
    for (int i = 0; i < NUM_MODULES; i++) begin
      bank = i[5];
      slot = i[4:0];
      lit  = slot_present(bank, slot) &&
             (slot_always_on(bank, slot) || (!bank && slot == DSP_SLOT));
      state_q[i]  = lit ? STATE_ON : 2'd0;
      ctrl_q[i]   = lit ? 9'(STATE_ON) : 9'd0;
      if (!bank && slot == DSP_SLOT) ctrl_q[i] = CTRL_DSP;
      target_q[i] = 2'd0;
    end
    for (int k = 0; k < NUM_DOMAINS; k++) countdown_q[k] = 8'd0;
    ticks_q = TICKS_RESET;
    owed_results.delete();
  endfunction

  // busy domains keep running, idle ones latch targets and restart
  function automatic void launch_domains(logic bank, logic [1:0] sel);
    for (int d = 0; d < 2; d++) begin
      if (sel[d] && countdown_q[{bank, d[0]}] == 8'd0) begin
        for (int m = 0; m < 32; m++) begin
          if (slot_present(bank, 5'(m)) && slot_domain(bank, 5'(m)) == d[0]) begin
            target_q[{bank, 5'(m)}] = slot_always_on(bank, 5'(m)) ?
                                      STATE_ON : ctrl_q[{bank, 5'(m)}][1:0];
          end
        end
        countdown_q[{bank, d[0]}] = ticks_q;
      end
    end
  endfunction

  function automatic void count_tick();
    for (int k = 0; k < NUM_DOMAINS; k++) begin
      if (countdown_q[k] != 8'd0) begin
        countdown_q[k]--;
        if (countdown_q[k] == 8'd0) begin
          for (int m = 0; m < 32; m++) begin
            if (slot_present(k[1], 5'(m)) && slot_domain(k[1], 5'(m)) == k[0])
              state_q[{k[1], 5'(m)}] = target_q[{k[1], 5'(m)}];
          end
        end
      end
    end
  endfunction

  function automatic bus_resp_t access_result(psc_op_t op, logic [31:0] addr,
                                              logic [63:0] wdata, logic [3:0] size,
                                              logic commit);
    bus_resp_t  r;
    logic       mapped;
    logic       bank;
    logic [11:0] off;
    logic [4:0] slot;
    logic [5:0] idx;
    logic       dsp;
    logic [63:0] allowed;
    r      = '0;
    mapped = addr[1:0] == 2'b00 &&
             (addr[31:12] == BANK0_PAGE || addr[31:12] == BANK1_PAGE);
    bank   = addr[31:12] == BANK1_PAGE;
    off    = addr[11:0];
    slot   = off[6:2];
    idx    = {bank, slot};
    case (op)
      OP_READ: begin
        if (mapped) begin
          if (off == OFF_GO) begin
            r.accepted = 1'b1;
          end else if (off == OFF_BUSY) begin
            r.accepted  = 1'b1;
            r.read_data = {30'd0, countdown_q[{bank, 1'b1}] != 8'd0,
                           countdown_q[{bank, 1'b0}] != 8'd0};
          end else if ((off[11:7] == STATUS_REGION || off[11:7] == CTRL_REGION) &&
                       slot_present(bank, slot)) begin
            r.accepted  = 1'b1;
            r.read_data = off[11:7] == STATUS_REGION ? status_word(state_q[idx])
                                                     : 32'(ctrl_q[idx]);
          end
        end
      end
      OP_WRITE: begin
        if (mapped && size == WR_SIZE) begin
          if (off[11:7] == CTRL_REGION) begin
            dsp     = !bank && slot == DSP_SLOT;
            allowed = dsp ? 64'(CTRL_DSP) : CTRL_FIELD_MASK;
            if (slot_present(bank, slot) && (wdata & ~allowed) == 64'd0 &&
                (!dsp || wdata == 64'(CTRL_DSP))) begin
              r.accepted = 1'b1;
              if (commit) ctrl_q[idx] = wdata[8:0];
            end
          end else if (off == OFF_GO && wdata[63:2] == '0) begin
            r.accepted = 1'b1;
            if (commit) launch_domains(bank, wdata[1:0]);
          end
        end
      end
      OP_TICK: begin
        r.accepted = 1'b1;
        count_tick();
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void log_mismatch(string field, logic [31:0] want, logic [31:0] got);
    error_count++;
    if (error_count <= 10)
      $display("result %0d: %s expected %h got %h", results_seen, field, want, got);
  endfunction

  always @(posedge clk) begin
    bus_resp_t want;
    if (!rst_n) begin
      load_boot();
    end else begin
      if (cfg_we) ticks_q = cfg_wdata;
      if (in_valid && in_ready)
        owed_results.push_back(access_result(psc_op_t'(in_opcode), in_bus_address,
                                             in_write_data, in_access_size, in_commit));
      if (out_valid && out_ready) begin
        results_seen++;
        if (owed_results.size() == 0) begin
          log_mismatch("result with none pending, read_data", 32'd0, out_read_data);
        end else begin
          want = owed_results.pop_front();
          if (out_accepted !== want.accepted)
            log_mismatch("accepted", 32'(want.accepted), 32'(out_accepted));
          if (out_read_data !== want.read_data)
            log_mismatch("read_data", want.read_data, out_read_data);
        end
      end
    end
    responses_due = owed_results.size();
  end

endmodule

/* test/power_sleep_controller_regs_tb.sv */
module power_sleep_controller_regs_tb;
  import psc_pkg::*;

  // watchdog limit, leaving room above the slowest legal run
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned OUT_HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS     = 130;
  localparam int unsigned DRAIN_CYCLES    = 100;
  localparam int unsigned NUM_PHASES      = 6;

  // one bus transfer on the input channel
  typedef struct packed {
    psc_op_t     op;
    logic [31:0] addr;
    logic [63:0] data;
    logic [3:0]  size;
    logic        commit;
  } bus_item_t;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic [1:0]  in_opcode      = 2'd0;
  logic [31:0] in_bus_address = 32'd0;
  logic [63:0] in_write_data  = 64'd0;
  logic [3:0]  in_access_size = 4'd0;
  logic        in_commit      = 1'b0;
  logic        out_ready      = 1'b0;
  logic        cfg_we         = 1'b0;
  logic [7:0]  cfg_wdata      = 8'd0;
  logic        in_ready;
  logic        out_valid;
  logic        out_accepted;
  logic [31:0] out_read_data;

  int unsigned error_count;
  int unsigned responses_due;

  // knobs and counters of the stimulus, receiver and watchdog processes
  bit          no_idle    = 1'b0;
  bit          hold_req   = 1'b0;
  int unsigned items_sent = 0;
  int unsigned cycles     = 0;
  int          stall_left = 0;
  logic [7:0]  cur_ticks  = TICKS_RESET;

  power_sleep_controller_regs DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_bus_address (in_bus_address),
    .in_write_data  (in_write_data),
    .in_access_size (in_access_size),
    .in_commit      (in_commit),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_accepted   (out_accepted),
    .out_read_data  (out_read_data),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  psc_regs_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_bus_address (in_bus_address),
    .in_write_data  (in_write_data),
    .in_access_size (in_access_size),
    .in_commit      (in_commit),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_accepted   (out_accepted),
    .out_read_data  (out_read_data),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .error_count    (error_count),
    .responses_due  (responses_due)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog, counted in its own process
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("power_sleep_controller_regs regression: fail");
    $finish;
  end

  // mostly zero or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver: random backpressure, plus one long hold when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        out_ready = 1'b0;
        repeat (OUT_HOLD_CYCLES) @(negedge clk);
      end else if (no_idle) begin
        out_ready  = 1'b1;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  function automatic bus_item_t bus_item(psc_op_t op, logic [31:0] addr, logic [63:0] data,
                                         logic [3:0] size, logic commit);
    bus_item_t it;
    it.op     = op;
    it.addr   = addr;
    it.data   = data;
    it.size   = size;
    it.commit = commit;
    return it;
  endfunction

  function automatic bus_item_t rd(logic [31:0] addr);
    return bus_item(OP_READ, addr, 64'd0, WR_SIZE, 1'b0);
  endfunction

  function automatic bus_item_t wr(logic [31:0] addr, logic [63:0] data);
    return bus_item(OP_WRITE, addr, data, WR_SIZE, 1'b1);
  endfunction

  // ticks ignore address, data, size and commit, so those are noise
  function automatic bus_item_t tick_item();
    return bus_item(OP_TICK, $urandom, {$urandom, $urandom}, 4'($urandom), 1'($urandom));
  endfunction

  function automatic logic [31:0] reg_addr(logic bank, logic [11:0] off);
    return {bank ? BANK1_PAGE : BANK0_PAGE, off};
  endfunction

  function automatic logic [11:0] ctrl_off(logic [4:0] slot);
    return {CTRL_REGION, slot, 2'b00};
  endfunction

  function automatic logic [11:0] status_off(logic [4:0] slot);
    return {STATUS_REGION, slot, 2'b00};
  endfunction

  function automatic logic [4:0] pick_slot(logic bank);
    logic [4:0] slot;
    do slot = 5'($urandom);
    while (!(bank ? POP_MASK_B1[slot] : POP_MASK_B0[slot]));
    return slot;
  endfunction

  // mostly register offsets, some raw window offsets and fully random addresses
  function automatic logic [31:0] random_addr();
    logic       bank;
    logic [4:0] slot;
    bank = 1'($urandom);
    slot = 5'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2: return reg_addr(bank, ctrl_off(slot));
      3, 4, 5: return reg_addr(bank, status_off(slot));
      6:       return reg_addr(bank, OFF_GO);
      7:       return reg_addr(bank, OFF_BUSY);
      8:       return reg_addr(bank, 12'($urandom));
      default: return $urandom;
    endcase
  endfunction

  function automatic bus_item_t noise_item();
    int          r;
    psc_op_t     op;
    logic [63:0] data;
    r  = $urandom_range(0, 19);
    op = r < 8 ? OP_READ : r < 15 ? OP_WRITE : r < 19 ? OP_TICK : OP_NONE;
    case ($urandom_range(0, 3))
      0:       data = {$urandom, $urandom};
      1:       data = 64'($urandom_range(0, 3));
      2:       data = 64'(CTRL_DSP);
      default: data = 64'd1 << $urandom_range(0, 63);
    endcase
    return bus_item(op, random_addr(), data,
                    $urandom_range(0, 5) == 0 ? 4'($urandom) : WR_SIZE,
                    $urandom_range(0, 4) != 0);
  endfunction

  // present one transfer at the falling edge, hold it until taken
  task automatic offer(input bus_item_t item);
    int gap;
    in_opcode      = item.op;
    in_bus_address = item.addr;
    in_write_data  = item.data;
    in_access_size = item.size;
    in_commit      = item.commit;
    in_valid       = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // sender stops until every result is back, block is then idle
  task automatic wait_drained();
    in_valid = 1'b0;
    while (responses_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_ticks(input logic [7:0] value);
    wait_drained();
    cfg_wdata = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    cur_ticks = value;
  endtask

  // program some modules, start a domain, tick it along, look at the result
  task automatic power_sequence();
    logic       bank;
    logic [4:0] slot;
    int         n;
    bank = 1'($urandom);
    repeat ($urandom_range(1, 4)) begin
      slot = pick_slot(bank);
      // the dsp slot only takes its boot value
      offer(wr(reg_addr(bank, ctrl_off(slot)),
               (!bank && slot == DSP_SLOT) ? 64'(CTRL_DSP) : 64'($urandom_range(0, 3))));
    end
    offer(bus_item(OP_WRITE, reg_addr(bank, OFF_GO), 64'($urandom_range(1, 3)), WR_SIZE,
                   $urandom_range(0, 7) != 0));
    offer(rd(reg_addr(bank, OFF_BUSY)));
    n = $urandom_range(0, (cur_ticks > 12 ? 12 : int'(cur_ticks)) + 2);
    repeat (n) offer(tick_item());
    repeat ($urandom_range(1, 3)) begin
      slot = pick_slot(bank);
      offer(rd(reg_addr(bank, $urandom_range(0, 3) == 0 ? ctrl_off(slot)
                                                       : status_off(slot))));
    end
  endtask

  task automatic run_items(input int unsigned count);
    int unsigned base;
    base = items_sent;
    while (items_sent - base < count) begin
      if ($urandom_range(0, 9) < 7) power_sequence();
      else offer(noise_item());
    end
  endtask

  // longest countdown: start everything and tick until it lands
  task automatic long_transition();
    offer(wr(reg_addr(1'b0, OFF_GO), 64'h3));
    offer(wr(reg_addr(1'b1, OFF_GO), 64'h3));
    repeat (256) offer(tick_item());
    offer(rd(reg_addr(1'b0, OFF_BUSY)));
    offer(rd(reg_addr(1'b1, OFF_BUSY)));
  endtask

  initial begin
    logic [7:0] phase_ticks [NUM_PHASES];
    // extremes first, zero leaves started domains idle for good
    phase_ticks = '{8'd1, 8'd3, 8'd255, 8'd0, 8'd2, 8'd0};
    phase_ticks[5] = 8'($urandom_range(4, 254));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed reads: go, busy, boot values of the dsp slot and an always-on slot
    offer(rd(reg_addr(1'b0, OFF_GO)));
    offer(rd(reg_addr(1'b0, OFF_BUSY)));
    offer(rd(reg_addr(1'b0, status_off(DSP_SLOT))));
    offer(rd(reg_addr(1'b0, ctrl_off(DSP_SLOT))));
    offer(rd(reg_addr(1'b1, status_off(LAST_SLOT))));
    // unaligned, outside both windows, unused window word, unpopulated slot
    offer(rd(reg_addr(1'b0, status_off(5'd0)) | 32'd2));
    offer(rd(32'hffff_ffff));
    offer(rd(reg_addr(1'b0, 12'h000) - 32'd4));
    offer(rd(reg_addr(1'b1, 12'hffc)));
    offer(rd(reg_addr(1'b0, status_off(5'd6))));
    // a read ignores data, size and commit
    offer(bus_item(OP_READ, reg_addr(1'b1, ctrl_off(5'd1)), '1, 4'hf, 1'b1));
    // write rules: size, validate only, stray bits, dsp slot value
    offer(bus_item(OP_WRITE, reg_addr(1'b0, ctrl_off(5'd0)), 64'h2, 4'd8, 1'b1));
    offer(bus_item(OP_WRITE, reg_addr(1'b0, ctrl_off(5'd0)), 64'h1, WR_SIZE, 1'b0));
    offer(wr(reg_addr(1'b0, ctrl_off(5'd0)), 64'h4));
    offer(wr(reg_addr(1'b0, ctrl_off(DSP_SLOT)), 64'h3));
    offer(wr(reg_addr(1'b0, ctrl_off(DSP_SLOT)), 64'(CTRL_DSP)));
    offer(wr(reg_addr(1'b0, ctrl_off(5'd0)), 64'h2));
    // go with a stray bit and a write to the busy word are rejected
    offer(wr(reg_addr(1'b0, OFF_GO), 64'h4));
    offer(wr(reg_addr(1'b0, OFF_BUSY), 64'h1));
    // start both domains, then a second go while busy is ignored
    offer(wr(reg_addr(1'b0, OFF_GO), 64'h3));
    offer(wr(reg_addr(1'b0, OFF_GO), 64'h1));
    offer(rd(reg_addr(1'b0, OFF_BUSY)));
    repeat (8) offer(tick_item());
    offer(rd(reg_addr(1'b0, status_off(5'd0))));
    offer(bus_item(OP_NONE, reg_addr(1'b0, OFF_GO), 64'h3, WR_SIZE, 1'b1));
    offer(wr(reg_addr(1'b1, OFF_GO), 64'hffff_ffff_ffff_fffe));

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_ticks(phase_ticks[p]);
      // one phase runs with no idling on either side
      no_idle = (p == 4);
      // long receiver hold while the sender keeps offering
      if (p == 1) hold_req = 1'b1;
      if (phase_ticks[p] == 8'd255) long_transition();
      if (p == 3) begin
        run_items(PHASE_ITEMS / 2);
        wait_drained();
        run_items(PHASE_ITEMS / 2);
      end else begin
        run_items(PHASE_ITEMS);
      end
    end

    no_idle  = 1'b0;
    in_valid = 1'b0;
    while (responses_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0)
      $display("power_sleep_controller_regs regression: pass");
    else
      $display("power_sleep_controller_regs regression: fail");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/psc_pkg.sv
rtl/psc_decode.sv
rtl/power_sleep_controller_regs.sv
test/psc_regs_checker.sv
test/power_sleep_controller_regs_tb.sv
